>>> rtl/core/superpixel_distance_assign_macros.svh
// ---------------------------------------------------------------------------
// superpixel distance assign assertion macros
// Shared concurrent check templates, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SUPERPIXEL_DISTANCE_ASSIGN_MACROS_SVH
`define SUPERPIXEL_DISTANCE_ASSIGN_MACROS_SVH

// same-cycle implication
`define SDA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sda_pkg.sv
// ---------------------------------------------------------------------------
// sda_pkg
// Shared types and constants of the superpixel distance assignment block.
// ---------------------------------------------------------------------------
package sda_pkg;

  localparam logic [19:0] DIST_MAX = 20'hFFFFF;

  // square root pipeline: one result bit per stage plus a rounding stage
  localparam int SQ_W     = 36;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int SQ_LAT   = SQ_STEPS + 1;

  // queue between front and back, also the credit limit of the input
  localparam int QDEPTH = 32;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int OCC_W  = $clog2(QDEPTH + 1);

  localparam logic [8:0]  RADIUS_RESET = 9'd16;
  localparam logic [15:0] WEIGHT_RESET = 16'd2560;

  typedef enum logic [0:0] {
    CFG_WINDOW_RADIUS  = 1'b0,
    CFG_SPATIAL_WEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    KIND_CLEAR = 1'b0,
    KIND_OFFER = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [8:0]         row;
    logic [8:0]         col;
    logic [14:0]        pix_l;
    logic signed [15:0] pix_a;
    logic signed [15:0] pix_b;
    logic [11:0]        center_label;
    logic [12:0]        center_row;
    logic [12:0]        center_col;
    logic [14:0]        center_l;
    logic signed [15:0] center_a;
    logic signed [15:0] center_b;
  } item_t;

  // per-item data carried alongside the arithmetic
  typedef struct packed {
    kind_t       kind;
    logic        win;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [11:0] label;
  } meta_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        win;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [11:0] label;
    logic [19:0] distance;
  } entry_t;

endpackage

>>> rtl/core/sda_sqrt.sv
// ---------------------------------------------------------------------------
// sda_sqrt
// Pipelined integer square root, one result bit per stage, round to nearest.
// ---------------------------------------------------------------------------
module sda_sqrt (
  input  logic                     clk,
  input  logic [sda_pkg::SQ_W-1:0] din,
  output logic [17:0]              root
);

  localparam int N = sda_pkg::SQ_STEPS;

  logic [sda_pkg::SQ_W-1:0] rad_r  [N];
  logic [20:0]              rem_r  [N];
  logic [17:0]              root_r [N];
  logic [17:0]              root_out_r;

  // one restoring step per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [sda_pkg::SQ_W-1:0] rad_in;
    logic [20:0]              rem_in;
    logic [17:0]              root_in;
    logic [20:0]              rem_sh;
    logic [20:0]              trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign rad_in  = din;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign rem_sh = {rem_in[18:0], rad_in[sda_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      rad_r[k]  <= {rad_in[sda_pkg::SQ_W-3:0], 2'b00};
      rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[k] <= {root_in[16:0], ge};
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    root_out_r <= root_r[N-1] + 18'(rem_r[N-1] > {3'b000, root_r[N-1]});
  end

  assign root = root_out_r;

endmodule

>>> rtl/core/sda_front.sv
// ---------------------------------------------------------------------------
// sda_front
// Window test and 5D distance pipeline; pushes one classified entry per item.
// ---------------------------------------------------------------------------
module sda_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sda_pkg::item_t       in_item,
  input  logic [8:0]           window_radius,
  input  logic [15:0]          spatial_weight,
  output logic                 push,
  output sda_pkg::entry_t      push_entry
);

  localparam int DL = sda_pkg::SQ_LAT;

  // stage 0: input register
  logic           v0_r;
  sda_pkg::item_t it0_r;

  // stage 1: absolute differences and window test
  logic           v1_r;
  sda_pkg::meta_t m1_r;
  logic [14:0]    adl_r;
  logic [15:0]    ada_r, adb_r;
  logic [12:0]    adr_r, adc_r;

  // stage 2: squares
  logic           v2_r;
  sda_pkg::meta_t m2_r;
  logic [29:0]    sql_r;
  logic [31:0]    sqa_r, sqb_r;
  logic [25:0]    sqr_r, sqc_r;

  // stage 3: sums feeding the square roots
  logic                     v3_r;
  sda_pkg::meta_t           m3_r;
  logic [sda_pkg::SQ_W-1:0] lab_sum_r, xy_sum_r;

  // delay line across the square roots
  logic           vd_r [DL];
  sda_pkg::meta_t md_r [DL];

  logic [17:0] dlab, dxy;

  // stage 4: spatial product
  logic           v4_r;
  sda_pkg::meta_t m4_r;
  logic [17:0]    dlab4_r;
  logic [33:0]    prod_r;

  // stage 5: final distance
  logic            v5_r;
  sda_pkg::entry_t e5_r;

  logic signed [14:0] dr, dc;
  logic signed [15:0] dl;
  logic signed [16:0] da, db;
  logic [12:0]        lim;
  logic [12:0]        adr, adc;
  logic [34:0]        sp_sum;
  logic [23:0]        d_full;

  function automatic logic [12:0] in_item_row4(input logic [8:0] v);
    in_item_row4 = {v, 4'b0000};
  endfunction

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int i = 0; i < DL; i++) vd_r[i] <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r[0] <= v3_r;
      for (int i = 1; i < DL; i++) vd_r[i] <= vd_r[i-1];
      v4_r <= vd_r[DL-1];
      v5_r <= v4_r;
    end
  end

  // differences against the center
  always_comb begin
    dr  = $signed({2'b00, in_item_row4(it0_r.row)}) - $signed({2'b00, it0_r.center_row});
    dc  = $signed({2'b00, in_item_row4(it0_r.col)}) - $signed({2'b00, it0_r.center_col});
    dl  = $signed({1'b0, it0_r.pix_l}) - $signed({1'b0, it0_r.center_l});
    da  = 17'(it0_r.pix_a) - 17'(it0_r.center_a);
    db  = 17'(it0_r.pix_b) - 17'(it0_r.center_b);
    lim = {window_radius, 4'b0000};
    adr = dr[14] ? 13'(-dr) : 13'(dr);
    adc = dc[14] ? 13'(-dc) : 13'(dc);
  end

  // payload stages
  always_ff @(posedge clk) begin
    it0_r <= in_item;

    m1_r.kind  <= it0_r.kind;
    m1_r.win   <= (adr <= lim) && (adc <= lim);
    m1_r.row   <= it0_r.row;
    m1_r.col   <= it0_r.col;
    m1_r.label <= it0_r.center_label;
    adl_r <= dl[15] ? 15'(-dl) : 15'(dl);
    ada_r <= da[16] ? 16'(-da) : 16'(da);
    adb_r <= db[16] ? 16'(-db) : 16'(db);
    adr_r <= adr;
    adc_r <= adc;

    m2_r  <= m1_r;
    sql_r <= adl_r * adl_r;
    sqa_r <= ada_r * ada_r;
    sqb_r <= adb_r * adb_r;
    sqr_r <= adr_r * adr_r;
    sqc_r <= adc_r * adc_r;

    m3_r      <= m2_r;
    lab_sum_r <= 36'(sql_r) + 36'(sqa_r) + 36'(sqb_r);
    xy_sum_r  <= {1'b0, 27'(27'(sqr_r) + 27'(sqc_r)), 8'h00};

    md_r[0] <= m3_r;
    for (int i = 1; i < DL; i++) md_r[i] <= md_r[i-1];

    m4_r    <= md_r[DL-1];
    dlab4_r <= dlab;
    prod_r  <= dxy * spatial_weight;

    e5_r.kind     <= m4_r.kind;
    e5_r.win      <= m4_r.win;
    e5_r.row      <= m4_r.row;
    e5_r.col      <= m4_r.col;
    e5_r.label    <= m4_r.label;
    e5_r.distance <= (d_full > 24'(sda_pkg::DIST_MAX)) ? sda_pkg::DIST_MAX : d_full[19:0];
  end

  // rounded spatial term plus color term
  always_comb begin
    sp_sum = 35'(prod_r) + 35'd2048;
    d_full = 24'(dlab4_r) + 24'(sp_sum[34:12]);
  end

  sda_sqrt u_sqrt_lab (
    .clk  (clk),
    .din  (lab_sum_r),
    .root (dlab)
  );

  sda_sqrt u_sqrt_xy (
    .clk  (clk),
    .din  (xy_sum_r),
    .root (dxy)
  );

  assign push       = v5_r;
  assign push_entry = e5_r;

endmodule

>>> rtl/core/sda_queue.sv
// ---------------------------------------------------------------------------
// sda_queue
// Entry queue between the distance pipeline and the memory update stage.
// ---------------------------------------------------------------------------
module sda_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sda_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            head_valid,
  output sda_pkg::entry_t head
);

  sda_pkg::entry_t                 slot_r [sda_pkg::QDEPTH];
  logic [sda_pkg::QAW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [sda_pkg::OCC_W-1:0]       cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + sda_pkg::OCC_W'(push) - sda_pkg::OCC_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  assign head_valid = cnt_r != '0;
  assign head       = slot_r[rd_ptr_r];

endmodule

>>> rtl/core/sda_back.sv
// ---------------------------------------------------------------------------
// sda_back
// Per-pixel best distance and label memory, read-compare-write and output.
// ---------------------------------------------------------------------------
module sda_back #(
  parameter int ROWS       = 512,
  parameter int COLS       = 512,
  parameter int LABEL_BITS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  sda_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [8:0]      out_row,
  output logic [8:0]      out_col,
  output logic [11:0]     out_label,
  output logic [19:0]     out_distance,
  output logic            out_updated
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = LABEL_BITS + 20;

  logic [WW-1:0] mem [DEPTH];

  logic            advance;
  logic [AW-1:0]   head_idx, cur_idx;
  logic            b2_valid_r;
  sda_pkg::entry_t b2_r;
  logic [WW-1:0]   rd_r;
  logic            fwd_valid_r;
  logic [AW-1:0]   fwd_idx_r;
  logic [WW-1:0]   fwd_word_r;
  logic [WW-1:0]   old_word, new_word;
  logic            in_range, upd;
  logic [LABEL_BITS+11:0] lbl_in_ext, lbl_out_ext;

  logic            out_valid_r;
  logic [8:0]      out_row_r, out_col_r;
  logic [11:0]     out_label_r;
  logic [19:0]     out_dist_r;
  logic            out_upd_r;

  assign advance  = !out_valid_r || out_ready;
  assign pop      = advance && head_valid;
  assign head_idx = AW'(head.row) * AW'(COLS) + AW'(head.col);
  assign cur_idx  = AW'(b2_r.row) * AW'(COLS) + AW'(b2_r.col);

  // stored word, bypassing the write of the item just ahead
  always_comb begin
    in_range    = (32'(b2_r.row) < ROWS) && (32'(b2_r.col) < COLS);
    old_word    = (fwd_valid_r && fwd_idx_r == cur_idx) ? fwd_word_r : rd_r;
    lbl_in_ext  = {{LABEL_BITS{1'b0}}, b2_r.label};
    new_word    = old_word;
    upd         = 1'b0;
    case (b2_r.kind)
      sda_pkg::KIND_CLEAR: new_word[19:0] = sda_pkg::DIST_MAX;
      sda_pkg::KIND_OFFER: begin
        if (b2_r.win && (old_word[19:0] > b2_r.distance)) begin
          new_word = {lbl_in_ext[LABEL_BITS-1:0], b2_r.distance};
          upd      = 1'b1;
        end
      end
      default: new_word = old_word;
    endcase
    lbl_out_ext = {12'h000, new_word[WW-1:20]};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b2_valid_r  <= pop;
      fwd_valid_r <= pop && b2_valid_r && in_range;
      out_valid_r <= b2_valid_r;
    end
  end

  // memory read and write
  always_ff @(posedge clk) begin
    if (pop) rd_r <= mem[head_idx];
    if (advance && b2_valid_r && in_range) mem[cur_idx] <= new_word;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) b2_r <= head;
    if (advance) begin
      fwd_idx_r   <= cur_idx;
      fwd_word_r  <= new_word;
      out_row_r   <= b2_r.row;
      out_col_r   <= b2_r.col;
      out_label_r <= in_range ? lbl_out_ext[11:0] : 12'h000;
      out_dist_r  <= in_range ? new_word[19:0] : sda_pkg::DIST_MAX;
      out_upd_r   <= in_range && upd;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_label    = out_label_r;
  assign out_distance = out_dist_r;
  assign out_updated  = out_upd_r;

endmodule

>>> rtl/core/superpixel_distance_assign.sv
// ---------------------------------------------------------------------------
// superpixel_distance_assign
// Superpixel assignment step: per-pixel best 5D distance and label.
// ---------------------------------------------------------------------------
// One item is accepted per clock while in_tready is high, and one result
// leaves per clock when the output is taken. An item passes a 25-stage
// distance pipeline, dominated by two 19-stage square root units, then a
// queue and a read-compare-write on the pixel memory. The input takes
// items while fewer than 32 are between the input and the memory stage,
// so output stalls reach the input only after that many.
// The per-pixel memory has no reset; clear each pixel before offering it.
// ---------------------------------------------------------------------------
`include "superpixel_distance_assign_macros.svh"

module superpixel_distance_assign #(
  parameter int ROWS       = 512,
  parameter int COLS       = 512,
  parameter int LABEL_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // row, col, pix_l, pix_a, pix_b, center_label, center_row, center_col,
  // center_l, center_a, center_b, zero pad
  input  logic [151:0] in_tdata,
  // kind
  input  logic         in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_row, out_col, label, distance, zero pad
  output logic [55:0]  out_tdata,
  // updated
  output logic         out_tuser,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [8:0]                     window_radius_r;
  logic [15:0]                    spatial_weight_r;
  logic [sda_pkg::OCC_W-1:0]      occ_r, occ_nxt;
  logic                           in_acc;
  sda_pkg::item_t                 item;
  logic                           push, pop, head_valid;
  sda_pkg::entry_t                push_entry, head;
  logic [8:0]                     res_row, res_col;
  logic [11:0]                    res_label;
  logic [19:0]                    res_dist;
  logic                           res_upd;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_radius_r  <= sda_pkg::RADIUS_RESET;
      spatial_weight_r <= sda_pkg::WEIGHT_RESET;
    end else if (cfg_valid) begin
      case (sda_pkg::cfg_index_t'(cfg_index))
        sda_pkg::CFG_WINDOW_RADIUS:  window_radius_r  <= cfg_data[8:0];
        sda_pkg::CFG_SPATIAL_WEIGHT: spatial_weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit count of items between input and memory stage
  assign in_tready = occ_r < sda_pkg::OCC_W'(sda_pkg::QDEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign occ_nxt   = occ_r + sda_pkg::OCC_W'(in_acc) - sda_pkg::OCC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else        occ_r <= occ_nxt;
  end

  // unpack input transfer
  always_comb begin
    item.kind         = sda_pkg::kind_t'(in_tuser);
    item.row          = in_tdata[8:0];
    item.col          = in_tdata[17:9];
    item.pix_l        = in_tdata[32:18];
    item.pix_a        = in_tdata[48:33];
    item.pix_b        = in_tdata[64:49];
    item.center_label = in_tdata[76:65];
    item.center_row   = in_tdata[89:77];
    item.center_col   = in_tdata[102:90];
    item.center_l     = in_tdata[117:103];
    item.center_a     = in_tdata[133:118];
    item.center_b     = in_tdata[149:134];
  end

  sda_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_acc),
    .in_item        (item),
    .window_radius  (window_radius_r),
    .spatial_weight (spatial_weight_r),
    .push           (push),
    .push_entry     (push_entry)
  );

  sda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sda_back #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .LABEL_BITS (LABEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_row      (res_row),
    .out_col      (res_col),
    .out_label    (res_label),
    .out_distance (res_dist),
    .out_updated  (res_upd)
  );

  // pack result transfer
  assign out_tdata = {6'b000000, res_dist, res_label, res_col, res_row};
  assign out_tuser = res_upd;

  // checks
  `SDA_CHECK(a_occ_bound, 1'b1, occ_r <= sda_pkg::OCC_W'(sda_pkg::QDEPTH), "credit count overflow")
  `SDA_CHECK(a_upd_below_max, out_tvalid && out_tuser, res_dist != sda_pkg::DIST_MAX, "update at max distance")
  `SDA_CHECK(a_oob_result, out_tvalid && (32'(res_row) >= ROWS), !out_tuser && res_dist == sda_pkg::DIST_MAX && res_label == 12'h000, "bad result for pixel off image")
  `SDA_CHECK_NEXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata), "result changed in stall")

endmodule
